// File: hdl/wws_pkg.sv
package wws_pkg;

   localparam int ANG_ONE  = 65536;
   localparam int TAB_LEN  = 24;
   localparam logic [31:0] GAIN_Q30 = 32'd652032874;

   // CORDIC unit operations
   typedef enum logic [1:0] {
      CORDIC_SINCOS = 2'd0,
      CORDIC_ATAN2  = 2'd1
   } cordic_op_type;

   function automatic logic [22:0] atan_entry(input logic [4:0] i);
      logic [22:0] r;
      unique case (i)
         5'd0:  r = 23'd2949120;
         5'd1:  r = 23'd1740967;
         5'd2:  r = 23'd919879;
         5'd3:  r = 23'd466945;
         5'd4:  r = 23'd234379;
         5'd5:  r = 23'd117304;
         5'd6:  r = 23'd58666;
         5'd7:  r = 23'd29335;
         5'd8:  r = 23'd14668;
         5'd9:  r = 23'd7334;
         5'd10: r = 23'd3667;
         5'd11: r = 23'd1833;
         5'd12: r = 23'd917;
         5'd13: r = 23'd458;
         5'd14: r = 23'd229;
         5'd15: r = 23'd115;
         5'd16: r = 23'd57;
         5'd17: r = 23'd29;
         5'd18: r = 23'd14;
         5'd19: r = 23'd7;
         5'd20: r = 23'd4;
         5'd21: r = 23'd2;
         5'd22: r = 23'd1;
         default: r = 23'd0;
      endcase
      return r;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;      // latch the accepted beat
      logic cordic_start;  // start CORDIC
      cordic_op_type cordic_op;
      logic atan_sel_max;  // atan2 operands: 0 = sums, 1 = max entry
      logic save_sincos;   // latch sine/cosine of the new sample
      logic save_avg_dir;
      logic save_max_dir;
      logic rd_issue;      // issue a ring read at rd_sel
      logic [1:0] rd_sel;  // 0 oldest, 1 newest, 2 walk pointer
      logic pop_oldest;
      logic overwrite;     // write newest slot
      logic append;        // write new slot
      logic drop_full;     // full ring drop
      logic acc_clear;
      logic acc_take;      // accumulate the entry just read
      logic walk_step;
      logic div_start;
      logic rsp_load;
   } wws_cmd_type;

   typedef struct packed {
      logic is_query;
      logic cordic_done;
      logic div_done;
      logic count_zero;
      logic ring_full;
      logic expired;       // read entry is at least max_age old
      logic same_second;   // read entry has time_now
      logic walk_last;
      logic rsp_busy;
   } wws_sts_type;

endpackage

// File: hdl/wws_ram.sv
module wws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/wws_cordic.sv
// Iterative CORDIC: one micro-rotation per cycle. Rotation mode gives the
// Q1.15 sine and cosine of a whole-degree angle, vectoring mode gives whole
// degrees of atan2(y, x).
module wws_cordic #(
   parameter int STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  wws_pkg::cordic_op_type op,
   input  logic [8:0]             deg_in,
   input  logic signed [26:0]     y_in,
   input  logic signed [26:0]     x_in,
   output logic                   done,
   output logic signed [15:0]     sin_out,
   output logic signed [15:0]     cos_out,
   output logic [8:0]             deg_out
);
   localparam int NSTEP = (STEPS < wws_pkg::TAB_LEN) ? STEPS : wws_pkg::TAB_LEN;
   localparam int CW = 5;

   // Sums reach 1024 * 32768 * 2^16 times the CORDIC gain: 51 bits is ample.
   logic signed [51:0] x_ff, x_in_w, y_ff, y_in_w;
   logic signed [31:0] z_ff, z_in_w;
   logic [CW-1:0]      i_ff, i_in;
   logic               busy_ff, busy_in;
   logic               rot_ff, rot_in;
   logic [1:0]         quad_ff, quad_in;   // 0 none, 1 plus, 2 minus
   logic               zero_ff, zero_in;
   logic               done_ff, done_in;
   logic signed [15:0] sin_ff, sin_in, cos_ff, cos_in;
   logic [8:0]         deg_ff, deg_in_w;

   function automatic logic signed [15:0] to_q15(input logic signed [51:0] v);
      logic signed [51:0] r;
      r = (v + 52'sd16384) >>> 15;
      if (r > 52'sd32767) return 16'sd32767;
      if (r < -52'sd32768) return -16'sd32768;
      return r[15:0];
   endfunction

   always_comb begin
      logic signed [51:0] dx, dy, fx, fy;
      logic signed [31:0] th, a, d;
      x_in_w = x_ff; y_in_w = y_ff; z_in_w = z_ff; i_in = i_ff;
      busy_in = busy_ff; rot_in = rot_ff; quad_in = quad_ff; zero_in = zero_ff;
      done_in = 1'b0; sin_in = sin_ff; cos_in = cos_ff; deg_in_w = deg_ff;
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      a  = {9'd0, wws_pkg::atan_entry(i_ff)};
      fx = '0; fy = '0; th = '0; d = '0;
      if (start) begin
         busy_in = 1'b1; i_in = '0;
         rot_in  = (op == wws_pkg::CORDIC_SINCOS);
         zero_in = (x_in == 27'sd0) && (y_in == 27'sd0);
         if (op == wws_pkg::CORDIC_SINCOS) begin
            th = {23'd0, deg_in};
            if (th > 32'sd180) th = th - 32'sd360;
            quad_in = 2'd0;
            if (th > 32'sd90) begin
               th = th - 32'sd90; quad_in = 2'd1;
            end else if (th < -32'sd90) begin
               th = th + 32'sd90; quad_in = 2'd2;
            end
            x_in_w = {20'd0, wws_pkg::GAIN_Q30};
            y_in_w = '0;
            z_in_w = th <<< 16;
         end else begin
            x_in_w = 52'(x_in) <<< 16;
            y_in_w = 52'(y_in) <<< 16;
            z_in_w = '0;
            if (x_in < 0) begin
               z_in_w = (y_in >= 0) ? 32'sd11796480 : -32'sd11796480;
               x_in_w = -x_in_w; y_in_w = -y_in_w;
            end
         end
      end else if (busy_ff) begin
         if (rot_ff ? (z_ff >= 0) : !(y_ff > 0)) begin
            x_in_w = rot_ff ? x_ff - dx : x_ff - dx;
            y_in_w = y_ff + dy;
            z_in_w = rot_ff ? z_ff - a : z_ff - a;
         end else begin
            x_in_w = x_ff + dx;
            y_in_w = y_ff - dy;
            z_in_w = z_ff + a;
         end
         // rotation (z>=0): x-=dx,y+=dy,z-=a ; vectoring (y<=0): x-=dx,y+=dy,z-=a
         i_in = i_ff + 1'b1;
         if (i_ff == CW'(NSTEP - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (done_ff) begin
         fx = x_ff; fy = y_ff;
         if (quad_ff == 2'd1) begin
            fx = -y_ff; fy = x_ff;
         end else if (quad_ff == 2'd2) begin
            fx = y_ff; fy = -x_ff;
         end
         sin_in = to_q15(fy);
         cos_in = to_q15(fx);
         d = z_ff / 32'sd65536;
         if (d < 0) d = d + 32'sd360;
         if (d >= 32'sd360) d = d - 32'sd360;
         if (d < 0) d = '0;
         deg_in_w = zero_ff ? 9'd0 : d[8:0];
      end
   end

   logic fin_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; fin_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; fin_ff <= done_ff;
      end
      x_ff <= x_in_w; y_ff <= y_in_w; z_ff <= z_in_w; i_ff <= i_in;
      rot_ff <= rot_in; quad_ff <= quad_in; zero_ff <= zero_in;
      sin_ff <= sin_in; cos_ff <= cos_in; deg_ff <= deg_in_w;
   end

   assign done    = fin_ff;
   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
   assign deg_out = deg_ff;
endmodule

// File: hdl/wws_divider.sv
// Restoring divider, one quotient bit per cycle: 26-bit sum over 11-bit count.
module wws_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [25:0] dividend,
   input  logic [10:0] divisor,
   output logic        done,
   output logic [25:0] quotient
);
   logic [25:0] q_ff, q_in;
   logic [11:0] r_ff, r_in;
   logic [10:0] d_ff;
   logic [4:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      logic [11:0] t;
      q_in = q_ff; r_in = r_ff; n_in = n_ff; busy_in = busy_ff; done_in = 1'b0;
      t = {r_ff[10:0], q_ff[25]};
      if (start) begin
         q_in = dividend; r_in = '0; n_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (t >= {1'b0, d_ff}) begin
            r_in = t - {1'b0, d_ff};
            q_in = {q_ff[24:0], 1'b1};
         end else begin
            r_in = t;
            q_in = {q_ff[24:0], 1'b0};
         end
         n_in = n_ff + 1'b1;
         if (n_ff == 5'd25) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; n_ff <= n_in;
      if (start) d_ff <= divisor;
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

// File: hdl/wws_datapath.sv
module wws_datapath #(
   parameter int DEPTH = 1024,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  wws_pkg::wws_cmd_type cmd,
   output wws_pkg::wws_sts_type sts,
   input  logic [79:0]         req_tdata,
   input  logic                req_tuser,
   input  logic                csr_valid,
   input  logic [15:0]         csr_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata
);
   localparam int AW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [15:0] max_age_ff;
   logic        is_query_ff;
   logic [31:0] now_ff;
   logic [15:0] speed_ff, window_ff;
   logic [8:0]  dir_ff;
   logic [AW-1:0]   oldest_ff, walk_ff;
   logic [CNTW-1:0] count_ff, walk_n_ff;
   logic        lost_ff;
   logic signed [15:0] new_sin_ff, new_cos_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0] rd_time;
   logic [15:0] rd_speed, rd_sin, rd_cos;
   logic        wr_en;
   logic [CNTW-1:0] acc_n_ff;
   logic [25:0] acc_sum_ff;
   logic signed [26:0] ssum_ff, csum_ff;
   logic [16:0] maxv_ff;
   logic signed [15:0] ms_ff, mc_ff;
   logic [8:0]  avg_dir_ff, max_dir_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic        cdone, ddone;
   logic signed [15:0] c_sin, c_cos;
   logic [8:0]  c_deg;
   logic [25:0] quot;
   logic        in_win;

   assign wr_addr = cmd.overwrite ? AW'(oldest_ff + AW'(count_ff - 1'b1))
                                  : AW'(oldest_ff + AW'(count_ff));
   assign wr_en = cmd.overwrite || cmd.append;

   always_comb begin
      unique case (cmd.rd_sel)
         2'd0: rd_addr = oldest_ff;
         2'd1: rd_addr = AW'(oldest_ff + AW'(count_ff - 1'b1));
         default: rd_addr = walk_ff;
      endcase
   end

   wws_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time (.clock, .wr_en, .wr_addr,
      .wr_data(now_ff), .rd_addr, .rd_data(rd_time));
   wws_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_speed (.clock, .wr_en, .wr_addr,
      .wr_data(speed_ff), .rd_addr, .rd_data(rd_speed));
   wws_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_sin (.clock, .wr_en, .wr_addr,
      .wr_data(new_sin_ff), .rd_addr, .rd_data(rd_sin));
   wws_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cos (.clock, .wr_en, .wr_addr,
      .wr_data(new_cos_ff), .rd_addr, .rd_data(rd_cos));

   wws_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .start(cmd.cordic_start), .op(cmd.cordic_op),
      .deg_in(dir_ff),
      .y_in(cmd.atan_sel_max ? 27'(ms_ff) : ssum_ff),
      .x_in(cmd.atan_sel_max ? 27'(mc_ff) : csum_ff),
      .done(cdone), .sin_out(c_sin), .cos_out(c_cos), .deg_out(c_deg));

   wws_divider u_div (.clock, .reset, .start(cmd.div_start), .dividend(acc_sum_ff),
      .divisor(11'(acc_n_ff)), .done(ddone), .quotient(quot));

   assign in_win = ({1'b0, rd_time} + {17'd0, window_ff}) > {1'b0, now_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= 16'd600;
         oldest_ff <= '0; count_ff <= '0; lost_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) max_age_ff <= csr_data;
         if (cmd.pop_oldest) begin
            oldest_ff <= AW'(oldest_ff + 1'b1);
            count_ff  <= count_ff - 1'b1;
         end
         if (cmd.drop_full) begin
            oldest_ff <= AW'(oldest_ff + 1'b1);
            lost_ff   <= 1'b1;
         end
         if (cmd.append && !cmd.drop_full) count_ff <= count_ff + 1'b1;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_req) begin
         is_query_ff <= req_tuser;
         now_ff      <= req_tdata[31:0];
         speed_ff    <= req_tdata[47:32];
         dir_ff      <= (req_tdata[56:48] >= 9'd360) ? req_tdata[56:48] - 9'd360
                                                     : req_tdata[56:48];
         window_ff   <= req_tdata[72:57];
      end
      if (cmd.save_sincos) begin
         new_sin_ff <= c_sin; new_cos_ff <= c_cos;
      end
      if (cmd.acc_clear) begin
         acc_n_ff <= '0; acc_sum_ff <= '0; ssum_ff <= '0; csum_ff <= '0;
         maxv_ff <= 17'h1FFFF; ms_ff <= '0; mc_ff <= '0;
         walk_ff <= oldest_ff; walk_n_ff <= '0;
      end
      if (cmd.walk_step) begin
         walk_ff <= AW'(walk_ff + 1'b1);
         walk_n_ff <= walk_n_ff + 1'b1;
      end
      if (cmd.acc_take && in_win) begin
         acc_n_ff   <= acc_n_ff + 1'b1;
         acc_sum_ff <= acc_sum_ff + 26'(rd_speed);
         ssum_ff    <= ssum_ff + 27'($signed(rd_sin));
         csum_ff    <= csum_ff + 27'($signed(rd_cos));
         if ($signed(maxv_ff) < $signed({1'b0, rd_speed})) begin
            maxv_ff <= {1'b0, rd_speed};
            ms_ff <= rd_sin; mc_ff <= rd_cos;
         end
      end
      if (cmd.save_avg_dir) avg_dir_ff <= c_deg;
      if (cmd.save_max_dir) max_dir_ff <= c_deg;
      if (cmd.rsp_load) begin
         rsp_data_ff <= {1'b0, lost_ff, 11'(acc_n_ff),
                         (acc_n_ff == '0) ? 9'd0 : max_dir_ff, maxv_ff,
                         (acc_n_ff == '0) ? 16'd0 : quot[15:0],
                         (acc_n_ff == '0) ? 9'd0 : avg_dir_ff};
      end
   end

   // Note: now_ff is 32 bits, window sits in the upper tdata bits (see top).
   assign sts.is_query    = is_query_ff;
   assign sts.cordic_done = cdone;
   assign sts.div_done    = ddone;
   assign sts.count_zero  = (count_ff == '0);
   assign sts.ring_full   = (count_ff == CNTW'(DEPTH));
   assign sts.expired     = ({1'b0, rd_time} + {17'd0, max_age_ff}) <= {1'b0, now_ff};
   assign sts.same_second = (rd_time == now_ff);
   assign sts.walk_last   = (walk_n_ff == count_ff);
   assign sts.rsp_busy    = rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// File: hdl/wws_control.sv
module wws_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output wws_pkg::wws_cmd_type cmd,
   input  wws_pkg::wws_sts_type sts
);
   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_SC_WAIT, S_P1_RD, S_P1_CHK, S_NEW_RD, S_NEW_CHK,
      S_P2_RD, S_P2_CHK, S_Q_RD, S_Q_ACC, S_A1_WAIT, S_A2_WAIT, S_DIV_WAIT,
      S_RESP, S_Q_START, S_WRITE_GAP
   } state_type;

   state_type state_ff, state_in;
   wws_pkg::wws_cmd_type c;
   logic waited_ff, waited_in;

   always_comb begin
      state_in = state_ff; waited_in = 1'b0;
      c = '0;
      c.cordic_op = wws_pkg::CORDIC_SINCOS;
      c.rd_sel = 2'd0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            c.load_req = 1'b1; state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.is_query) begin
               c.acc_clear = 1'b1; state_in = S_Q_START;
            end else begin
               c.cordic_start = 1'b1; state_in = S_SC_WAIT;
            end
         end
         S_SC_WAIT: if (sts.cordic_done) begin
            c.save_sincos = 1'b1; state_in = S_P1_RD;
         end
         S_P1_RD: begin
            if (sts.count_zero) state_in = S_NEW_CHK;
            else begin
               c.rd_issue = 1'b1; c.rd_sel = 2'd0; state_in = S_P1_CHK;
            end
         end
         S_P1_CHK: begin
            if (sts.expired) begin
               c.pop_oldest = 1'b1; state_in = S_P1_RD;
            end else state_in = S_NEW_RD;
         end
         S_NEW_RD: begin
            c.rd_sel = 2'd1; state_in = S_NEW_CHK; waited_in = 1'b1;
         end
         S_NEW_CHK: begin
            if (waited_ff && sts.same_second) c.overwrite = 1'b1;
            else begin
               c.append = 1'b1;
               c.drop_full = sts.ring_full;
            end
            state_in = S_WRITE_GAP;
         end
         S_WRITE_GAP: state_in = S_P2_RD;
         S_P2_RD: begin
            if (sts.count_zero) state_in = S_IDLE;
            else begin
               c.rd_sel = 2'd0; state_in = S_P2_CHK;
            end
         end
         S_P2_CHK: begin
            if (sts.expired) begin
               c.pop_oldest = 1'b1; state_in = S_P2_RD;
            end else state_in = S_IDLE;
         end
         S_Q_START: begin
            c.rd_sel = 2'd2; state_in = S_Q_RD;
         end
         S_Q_RD: begin
            if (sts.walk_last) begin
               c.cordic_start = 1'b1; c.cordic_op = wws_pkg::CORDIC_ATAN2;
               state_in = S_A1_WAIT;
            end else begin
               c.rd_sel = 2'd2; c.walk_step = 1'b1; state_in = S_Q_ACC;
            end
         end
         S_Q_ACC: begin
            c.acc_take = 1'b1; c.rd_sel = 2'd2; state_in = S_Q_RD;
         end
         S_A1_WAIT: if (sts.cordic_done) begin
            c.save_avg_dir = 1'b1;
            c.cordic_start = 1'b1; c.cordic_op = wws_pkg::CORDIC_ATAN2;
            c.atan_sel_max = 1'b1; state_in = S_A2_WAIT;
         end
         S_A2_WAIT: begin
            c.atan_sel_max = 1'b1;
            if (sts.cordic_done) begin
               c.save_max_dir = 1'b1; c.div_start = 1'b1; state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: if (sts.div_done) state_in = S_RESP;
         S_RESP: if (!sts.rsp_busy) begin
            c.rsp_load = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; waited_ff <= 1'b0;
      end else begin
         state_ff <= state_in; waited_ff <= waited_in;
      end
   end

   assign cmd = c;
   assign req_tready = (state_ff == S_IDLE);
endmodule

// File: hdl/windowed_wind_statistics.sv
// Windowed wind statistics. Store beats (tuser 0) put a time-stamped wind
// sample in a ring of DEPTH entries, replacing the newest entry of the same
// second and dropping entries at least max_age seconds old; a full ring drops
// its oldest entry and sets the sticky lost flag. Query beats (tuser 1) return
// one result beat over the entries newer than time_now - window. A store's
// time is set by the iterative sine/cosine CORDIC and by the ring walk over
// expired entries, each read from the registered ring before its check. A
// query's time grows with the stored entries, each read from the registered
// ring and then accumulated, and adds two atan2 CORDIC passes and the divider.
// The ring needs no clearing pass; only live entries are ever read.
module windowed_wind_statistics #(
   parameter int DEPTH = 1024,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: time_now[31:0], speed[47:32], direction[56:48],
   // window[72:57], zero fill to 80 bits.
   input  logic [79:0] req_tdata,
   // tuser: action (0 store, 1 query).
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: avg_direction[8:0], avg_speed[24:9], max_speed[41:25],
   // direction_at_max[50:42], sample_count[61:51], lost_samples[62], zero fill.
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   wws_pkg::wws_cmd_type cmd;
   wws_pkg::wws_sts_type sts;

   // The configuration register takes a write in any cycle.
   assign csr_ready = 1'b1;

   wws_control u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .cmd, .sts);

   // The datapath latches window from the top bits of the beat.
   wws_datapath #(.DEPTH(DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_tdata, .req_tuser, .csr_valid, .csr_data,
      .rsp_tvalid, .rsp_tready, .rsp_tdata);
endmodule

// File: hdl/wws_checker.sv
module wws_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   // A response never arrives in the cycle right after a request.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("response too early");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
   // An empty window reports max_speed of -1.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[61:51] == 11'd0) |-> rsp_tdata[41:25] == 17'h1FFFF)
      else $error("empty window max");
   // Sample count never exceeds the ring size.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[61:51] <= 11'd1024)
      else $error("count range");
endmodule

bind windowed_wind_statistics wws_checker u_chk (.clock, .reset, .req_tvalid,
   .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);
